>>> sv/rgpg_pkg.sv
// Shared types and constants for the radial gradient pixel generator.
// No dependencies; every other file in the block imports this package.
package rgpg_pkg;

  // Largest image side and radius. Register writes above it saturate.
  localparam int MAX_SIDE = 4096;

  localparam int SIDE_W  = 13;  // image_width, image_height, fade_radius
  localparam int COORD_W = 12;  // pixel_col, pixel_row
  localparam int LEVEL_W = 8;   // grey levels

  // Squared doubled distance, valid range below 4*radius^2 <= 2^26.
  localparam int D2_W    = 26;
  localparam int FRAC_W  = 8;                  // fractional bits of the root
  localparam int RAD_W   = D2_W + 2 * FRAC_W;  // radicand d2 * 65536
  localparam int ROOT_W  = RAD_W / 2;          // one root bit per cell
  localparam int REM_W   = ROOT_W + 2;         // root remainder, <= 2*root
  localparam int N_SQRT  = ROOT_W;

  // Divisor is 512 * radius; the divider works against it scaled by 128.
  localparam int DEN_W   = SIDE_W + 16;
  localparam int DREM_W  = DEN_W + 1;
  localparam int PROD_W  = ROOT_W + LEVEL_W;
  localparam int N_DIV   = LEVEL_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_RADIUS  = 3'd4;

  typedef struct packed {
    logic [SIDE_W-1:0]  image_width;
    logic [SIDE_W-1:0]  image_height;
    logic [SIDE_W-1:0]  fade_radius;
  } cfg_t;

  // Data handed from one square-root cell to the next.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              in_ramp;
  } sq_t;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic [DREM_W-1:0]  rem;
    logic [LEVEL_W-1:0] quo;
    logic               in_ramp;
  } dv_t;

endpackage

>>> sv/rgpg_front.sv
// Front end: doubled offsets from the centre, their squares, and the radius test.
// Depends on rgpg_pkg. Three registered stages with a per-stage ready chain.
module rgpg_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rgpg_pkg::cfg_t              cfg,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [rgpg_pkg::COORD_W-1:0] pixel_col,
  input  logic [rgpg_pkg::COORD_W-1:0] pixel_row,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output rgpg_pkg::sq_t               dn_data
);
  import rgpg_pkg::*;

  localparam int DX_W = SIDE_W + 2;

  logic [2:0]            v_r;
  logic [2:0]            rdy;
  logic [DX_W-1:0]       dx, dy;
  logic [SIDE_W-1:0]     adx_r, ady_r;
  logic [2*SIDE_W-1:0]   sqx_r, sqy_r;
  logic [2*SIDE_W:0]     d2_sum;
  logic [SIDE_W:0]       two_r;
  logic [2*SIDE_W:0]     lim_r;
  logic [D2_W-1:0]       d2_r;
  logic                  inside_r;

  assign rdy[2]   = !v_r[2] || dn_ready;
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign up_ready = rdy[0];

  assign dx = {2'b00, pixel_col, 1'b0} - {2'b00, cfg.image_width} + DX_W'(1);
  assign dy = {2'b00, pixel_row, 1'b0} - {2'b00, cfg.image_height} + DX_W'(1);

  // Limit (2r)^2 follows the radius register; it settles long before use.
  assign two_r  = {cfg.fade_radius, 1'b0};
  assign d2_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    lim_r <= (2*SIDE_W+1)'(two_r * two_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      adx_r <= dx[DX_W-1] ? SIDE_W'(-dx) : dx[SIDE_W-1:0];
      ady_r <= dy[DX_W-1] ? SIDE_W'(-dy) : dy[SIDE_W-1:0];
    end
    if (rdy[1] && v_r[0]) begin
      sqx_r <= adx_r * adx_r;
      sqy_r <= ady_r * ady_r;
    end
    if (rdy[2] && v_r[1]) begin
      d2_r     <= d2_sum[D2_W-1:0];
      inside_r <= (cfg.fade_radius != '0) && (d2_sum < lim_r);
    end
  end

  assign dn_valid        = v_r[2];
  assign dn_data.rad     = {d2_r, {(2*FRAC_W){1'b0}}};
  assign dn_data.rem     = '0;
  assign dn_data.root    = '0;
  assign dn_data.in_ramp = inside_r;

endmodule

>>> sv/rgpg_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per cell.
// Depends on rgpg_pkg.
module rgpg_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  rgpg_pkg::sq_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output rgpg_pkg::sq_t dn_data
);
  import rgpg_pkg::*;

  logic             valid_r;
  sq_t              data_r, data_nxt;
  logic [REM_W+1:0] acc, sub;
  logic             fits;

  assign up_ready = !valid_r || dn_ready;

  // Bring down the next pair of radicand bits and try the root with a one appended.
  always_comb begin
    acc  = {up_data.rem, up_data.rad[RAD_W-1 -: 2]};
    sub  = {2'b00, up_data.root, 2'b01};
    fits = acc >= sub;
    data_nxt.rad     = {up_data.rad[RAD_W-3:0], 2'b00};
    data_nxt.in_ramp = up_data.in_ramp;
    if (fits) begin
      data_nxt.rem  = REM_W'(acc - sub);
      data_nxt.root = {up_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_nxt.rem  = acc[REM_W-1:0];
      data_nxt.root = {up_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.rem <= {1'b0, data_r.root, 1'b0}))
    else $error("square-root remainder exceeds twice the partial root");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !dn_ready) |=> (valid_r && $stable(data_r)))
    else $error("stalled square-root cell lost or changed its data");

endmodule

>>> sv/rgpg_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit per cell.
// Depends on rgpg_pkg.
module rgpg_div_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rgpg_pkg::DEN_W-1:0] den,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  rgpg_pkg::dv_t             up_data,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output rgpg_pkg::dv_t             dn_data
);
  import rgpg_pkg::*;

  logic              valid_r;
  dv_t               data_r, data_nxt;
  logic [DREM_W-1:0] diff;
  logic              fits;

  assign up_ready = !valid_r || dn_ready;

  // The divisor stays fixed and the remainder doubles after each trial.
  always_comb begin
    fits = up_data.rem >= {1'b0, den};
    diff = up_data.rem - {1'b0, den};
    data_nxt.in_ramp = up_data.in_ramp;
    if (fits) begin
      data_nxt.rem = {diff[DREM_W-2:0], 1'b0};
      data_nxt.quo = {up_data.quo[LEVEL_W-2:0], 1'b1};
    end else begin
      data_nxt.rem = {up_data.rem[DREM_W-2:0], 1'b0};
      data_nxt.quo = {up_data.quo[LEVEL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !dn_ready) |=> (valid_r && $stable(data_r)))
    else $error("stalled divider cell lost or changed its data");

endmodule

>>> sv/radial_gradient_pixel_generator.sv
// Top level of the radial gradient pixel generator: registers, cell chains, output.
// Depends on rgpg_pkg, rgpg_front, rgpg_sqrt_cell and rgpg_div_cell.
//
//   Channel   Direction   Handshake              Payload
//   in_       slave       in_tvalid/in_tready    tdata: pixel_col, pixel_row
//   out_      master      out_tvalid/out_tready  tdata: grey_level; tuser: inside_ramp
//   cfg_      write only  cfg_we                 cfg_index, cfg_wdata
//
// One transaction is accepted per clock while the output is not stalled, and each
// one passes 34 registered stages: three front stages, 21 square-root cells (one
// root bit each), one multiply stage, eight divider cells (one quotient bit each),
// and one output stage.
// The depth is set by the square-root chain, which needs a cell for every root bit.
// Reset is synchronous and active low; it empties every stage and restores the
// register defaults. Every stage has its own ready, so a stalled output only
// holds stages that are full, and empty stages further up keep taking transactions.
module radial_gradient_pixel_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input transactions. tdata[11:0] pixel_col, tdata[23:12] pixel_row.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,
  // Result transactions. tdata[7:0] grey_level.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,
  // tuser[0] inside_ramp.
  output logic                           out_tuser,
  // Configuration writes.
  input  logic                           cfg_we,
  input  logic [rgpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgpg_pkg::SIDE_W-1:0]    cfg_wdata
);
  import rgpg_pkg::*;

  // Configuration registers.
  logic [SIDE_W-1:0]  image_width_r, image_height_r, fade_radius_r;
  logic [LEVEL_W-1:0] inner_level_r, outer_level_r;
  logic [SIDE_W-1:0]  side_sat;
  cfg_t               cfg;

  // Sides and the radius saturate at the largest supported side.
  assign side_sat = (cfg_wdata > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= SIDE_W'(256);
      image_height_r <= SIDE_W'(256);
      inner_level_r  <= LEVEL_W'(255);
      outer_level_r  <= '0;
      fade_radius_r  <= SIDE_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= side_sat;
        REG_IMAGE_HEIGHT: image_height_r <= side_sat;
        REG_INNER_LEVEL:  inner_level_r  <= cfg_wdata[LEVEL_W-1:0];
        REG_OUTER_LEVEL:  outer_level_r  <= cfg_wdata[LEVEL_W-1:0];
        REG_FADE_RADIUS:  fade_radius_r  <= side_sat;
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  assign cfg.image_width  = image_width_r;
  assign cfg.image_height = image_height_r;
  assign cfg.fade_radius  = fade_radius_r;

  // Front end: squared doubled distance and the inside-radius flag.
  logic sv_valid [N_SQRT+1];
  logic sv_ready [N_SQRT+1];
  sq_t  sv_data  [N_SQRT+1];

  rgpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .pixel_col (in_tdata[COORD_W-1:0]),
    .pixel_row (in_tdata[2*COORD_W-1:COORD_W]),
    .dn_valid  (sv_valid[0]),
    .dn_ready  (sv_ready[0]),
    .dn_data   (sv_data[0])
  );

  // Square-root chain: the root of d2 * 65536, i.e. the doubled distance with eight
  // fractional bits, rounded down.
  for (genvar i = 0; i < N_SQRT; i++) begin : g_sqrt
    rgpg_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sv_valid[i]),
      .up_ready (sv_ready[i]),
      .up_data  (sv_data[i]),
      .dn_valid (sv_valid[i+1]),
      .dn_ready (sv_ready[i+1]),
      .dn_data  (sv_data[i+1])
    );
  end

  // Multiply stage: root times the level span.
  logic                mv_r;
  logic                mul_ready;
  logic [PROD_W-1:0]   prod_r;
  logic                minside_r;
  logic [LEVEL_W-1:0]  span;
  logic                rising;

  assign rising = outer_level_r >= inner_level_r;
  assign span   = rising ? (outer_level_r - inner_level_r) : (inner_level_r - outer_level_r);

  logic dvv   [N_DIV+1];
  logic dvr   [N_DIV+1];
  dv_t  dvd   [N_DIV+1];

  assign mul_ready        = !mv_r || dvr[0];
  assign sv_ready[N_SQRT] = mul_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (mul_ready) begin
      mv_r <= sv_valid[N_SQRT];
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && sv_valid[N_SQRT]) begin
      prod_r    <= sv_data[N_SQRT].root * span;
      minside_r <= sv_data[N_SQRT].in_ramp;
    end
  end

  assign dvv[0]         = mv_r;
  assign dvd[0].rem     = {1'b0, prod_r};
  assign dvd[0].quo     = '0;
  assign dvd[0].in_ramp = minside_r;

  // Divider chain against 512 * radius. The product stays below 256 times the
  // divisor inside the radius, so eight quotient bits are enough.
  logic [DEN_W-1:0] den;
  assign den = {fade_radius_r, 16'b0};

  for (genvar j = 0; j < N_DIV; j++) begin : g_div
    rgpg_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .den      (den),
      .up_valid (dvv[j]),
      .up_ready (dvr[j]),
      .up_data  (dvd[j]),
      .dn_valid (dvv[j+1]),
      .dn_ready (dvr[j+1]),
      .dn_data  (dvd[j+1])
    );
  end

  // Output register: the level moves from the inner level toward the outer one,
  // and pixels at or beyond the radius take the outer level.
  logic               ov_r;
  logic               out_ready;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               oinside_r;

  assign out_ready  = !ov_r || out_tready;
  assign dvr[N_DIV] = out_ready;

  always_comb begin
    if (!dvd[N_DIV].in_ramp) begin
      level_nxt = outer_level_r;
    end else if (rising) begin
      level_nxt = inner_level_r + dvd[N_DIV].quo;
    end else begin
      level_nxt = inner_level_r - dvd[N_DIV].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_ready) begin
      ov_r <= dvv[N_DIV];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && dvv[N_DIV]) begin
      level_r   <= level_nxt;
      oinside_r <= dvd[N_DIV].in_ramp;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = level_r;
  assign out_tuser  = oinside_r;

  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mv_r && !dvr[0]) |=> (mv_r && $stable(prod_r)))
    else $error("stalled multiply stage lost or changed its product");

endmodule

>>> tb/radial_gradient_pixel_generator_test.sv
// Self-checking testbench for the radial gradient pixel generator.
// It needs rgpg_pkg and the radial_gradient_pixel_generator RTL; it carries its own
// predictor of the grey level and compares every result transaction against it.
module radial_gradient_pixel_generator_test;
  import rgpg_pkg::*;

  // The pipeline is 34 stages deep; this wait covers any result still in flight.
  localparam int DRAIN_CYCLES   = 40;
  // Longest deliberate output stall used by the back-pressure test.
  localparam int HOLD_CYCLES    = 400;
  // Cycles without any transaction on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  // How the result side paces its tready.
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_e;

  // One expected result, tagged with the pixel that caused it for readable reports.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [7:0]         grey;
    logic               in_ramp;
  } pixel_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIDE_W-1:0]    cfg_wdata = '0;

  // Shadow copy of the configuration registers, starting at their reset values.
  int unsigned grad_width  = 256;
  int unsigned grad_height = 256;
  int unsigned grad_inner  = 255;
  int unsigned grad_outer  = 0;
  int unsigned grad_radius = 128;

  // Results predicted for accepted pixels, oldest first.
  pixel_result_t expected_pixels[$];
  pixel_result_t oldest_pixel;
  int            failures = 0;

  // Stimulus pacing shared between the test tasks and the two channel processes.
  rx_style_e rx_style = RX_ALWAYS;
  bit        tx_gaps = 1'b0;
  int        burst_left = 0;
  int        hold_requests = 0;
  int        holds_served = 0;
  int        hold_left = 0;
  int        rx_cycle = 0;

  radial_gradient_pixel_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [11:0] pixel_col, [23:12] pixel_row
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] grey_level
    .out_tuser  (out_tuser),  // [0] inside_ramp
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Floor of the square root, found one result bit at a time from the top.
  function automatic longint unsigned floor_sqrt(longint unsigned radicand);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > radicand) probe >>= 2;
    while (probe != 0) begin
      if (radicand >= root + probe) begin
        radicand -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Side and radius registers clamp anything above the largest supported side.
  function automatic int unsigned side_limit(logic [SIDE_W-1:0] value);
    return (int'(value) > MAX_SIDE) ? MAX_SIDE : int'(value);
  endfunction

  // Grey level of one pixel. Distances are doubled so that the image centre lands
  // on whole numbers; the root of d2 carries 8 fractional bits, hence the 512 below
  // (two for the doubling times 256 for the fraction).
  function automatic pixel_result_t predict_pixel(logic [COORD_W-1:0] col,
                                                  logic [COORD_W-1:0] row);
    longint          dx;
    longint          dy;
    longint unsigned d2;
    longint unsigned rad;
    longint unsigned root;
    pixel_result_t   res;
    dx = 2 * longint'(col) - longint'(grad_width) + 1;
    dy = 2 * longint'(row) - longint'(grad_height) + 1;
    d2 = dx * dx + dy * dy;
    rad = grad_radius;
    res.col = col;
    res.row = row;
    res.grey = grad_outer[7:0];
    res.in_ramp = 1'b0;
    if (rad != 0 && d2 < 4 * rad * rad) begin
      root = floor_sqrt(d2 << 16);
      res.in_ramp = 1'b1;
      // The step toward the outer level is truncated, so the level never overshoots.
      if (grad_outer >= grad_inner) begin
        res.grey = 8'(grad_inner + (root * (grad_outer - grad_inner)) / (512 * rad));
      end else begin
        res.grey = 8'(grad_inner - (root * (grad_inner - grad_outer)) / (512 * rad));
      end
    end
    return res;
  endfunction

  // Writes one register and mirrors it. Only called while the block holds no pixel.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  grad_width  = side_limit(value);
      REG_IMAGE_HEIGHT: grad_height = side_limit(value);
      REG_INNER_LEVEL:  grad_inner  = 32'(value[7:0]);
      REG_OUTER_LEVEL:  grad_outer  = 32'(value[7:0]);
      REG_FADE_RADIUS:  grad_radius = side_limit(value);
      default: ;  // unused indexes are ignored by the block
    endcase
  endtask

  task automatic write_all(logic [SIDE_W-1:0] width, logic [SIDE_W-1:0] height,
                           logic [SIDE_W-1:0] inner, logic [SIDE_W-1:0] outer,
                           logic [SIDE_W-1:0] radius);
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_INNER_LEVEL, inner);
    write_reg(REG_OUTER_LEVEL, outer);
    write_reg(REG_FADE_RADIUS, radius);
  endtask

  // Offers one pixel and returns at the rising edge where the transaction happens.
  // The sender works in bursts; between bursts, when gaps are enabled, it may drop tvalid.
  // tready is sampled on the falling edge, when nothing can still be changing, and
  // the handshake then completes at the following rising edge.
  task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    if (burst_left == 0) begin
      if (tx_gaps) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row, col};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    expected_pixels.push_back(predict_pixel(col, row));
    burst_left--;
    @(posedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // Returns once every predicted result has come back, leaving the block idle.
  task automatic wait_drained();
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Largest in-image coordinate for a side, or zero for an empty side.
  function automatic int unsigned coord_top(int unsigned side);
    return (side == 0) ? 0 : side - 1;
  endfunction

  // Default registers: centre, corners, and pixels just inside and just outside
  // the ring where the distance meets the radius.
  task automatic test_reset_defaults();
    rx_style = RX_RANDOM;
    tx_gaps  = 1'b1;
    send_pixel(127, 127);
    send_pixel(128, 128);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(255, 128);
    send_pixel(256, 128);
    stop_sending();
    wait_drained();
  endtask

  // Oversized sides and radius saturate, a zero side is accepted, writes to unused
  // indexes change nothing, and a zero radius gives the outer level everywhere.
  task automatic test_register_extremes();
    write_all(13'h1FFF, 0, 0, 255, 13'h1FFF);
    for (int k = REG_FADE_RADIUS + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), (k[0]) ? 13'h1FFF : 13'h0000);
    end
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2048, 0);
    send_pixel(0, 4095);
    stop_sending();
    wait_drained();
    write_reg(REG_FADE_RADIUS, 0);
    send_pixel(2048, 2048);
    send_pixel(0, 0);
    stop_sending();
    wait_drained();
  endtask

  // With a one-pixel image the doubled distance is even, so a pixel can sit exactly
  // on the radius; it must count as outside. The ramp falls here, and a flat ramp follows.
  task automatic test_exact_radius();
    write_all(1, 1, 200, 10, 5);
    send_pixel(3, 4);
    send_pixel(4, 3);
    send_pixel(4, 2);
    send_pixel(0, 5);
    send_pixel(0, 0);
    stop_sending();
    wait_drained();
    write_reg(REG_OUTER_LEVEL, 200);
    send_pixel(1, 1);
    stop_sending();
    wait_drained();
  endtask

  // Picks an image side, biased toward small sizes with the extremes mixed in.
  function automatic logic [SIDE_W-1:0] pick_side();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return SIDE_W'(MAX_SIDE);
      3:       return SIDE_W'($urandom_range(MAX_SIDE + 1, 8191));
      4, 5, 6: return SIDE_W'($urandom_range(2, 64));
      default: return SIDE_W'($urandom_range(1, MAX_SIDE));
    endcase
  endfunction

  // Random configurations, each followed by a batch of random pixels. Most pixels
  // fall inside the image; the rest use the full coordinate range.
  task automatic test_random_configs();
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [SIDE_W-1:0] radius;
    int unsigned       span;
    for (int phase = 0; phase < 12; phase++) begin
      width  = (phase == 0) ? SIDE_W'(MAX_SIDE) : pick_side();
      height = (phase == 0) ? SIDE_W'(MAX_SIDE) : pick_side();
      span   = (side_limit(width) > side_limit(height)) ? side_limit(width)
                                                         : side_limit(height);
      case ($urandom_range(0, 7))
        0:       radius = 0;
        1:       radius = SIDE_W'(MAX_SIDE);
        2:       radius = SIDE_W'($urandom_range(MAX_SIDE + 1, 8191));
        default: radius = SIDE_W'($urandom_range(1, span / 2 + 2));
      endcase
      if (phase == 0) radius = SIDE_W'(MAX_SIDE);
      case (phase)
        0:       write_all(width, height, 0, 255, radius);
        1:       write_all(width, height, 255, 0, radius);
        default: write_all(width, height, SIDE_W'($urandom_range(0, 255)),
                           SIDE_W'($urandom_range(0, 255)), radius);
      endcase
      // Phase 0 runs with no idling at all on either side.
      rx_style = rx_style_e'(phase % 3);
      tx_gaps  = (phase % 4) != 0;
      repeat (75) begin
        if ($urandom_range(0, 4) == 0) begin
          send_pixel(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)));
        end else begin
          send_pixel(COORD_W'($urandom_range(0, coord_top(grad_width))),
                     COORD_W'($urandom_range(0, coord_top(grad_height))));
        end
      end
      stop_sending();
      wait_drained();
    end
  endtask

  // The result side holds tready low for a long stretch while pixels keep coming,
  // so the pipeline fills and pushes back on the input. Afterwards the sender stops
  // until everything is back, then resumes with random pacing.
  task automatic test_backpressure();
    write_all(64, 64, 30, 220, 40);
    rx_style = RX_ALWAYS;
    tx_gaps  = 1'b0;
    hold_requests++;
    repeat (100) send_pixel(COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)));
    stop_sending();
    wait_drained();
    rx_style = RX_RANDOM;
    tx_gaps  = 1'b1;
    repeat (25) send_pixel(COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)));
    stop_sending();
    wait_drained();
  endtask

  // Result-side pacing. A hold request from a test starts a long stall that is
  // counted here; otherwise tready follows the selected style.
  always @(posedge clk) begin
    rx_cycle++;
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_tready <= (rx_cycle % 7) < 4;
        default:    out_tready <= 1'b1;
      endcase
    end
  end

  // Result checker. Values are stable on the falling edge, so a transaction seen
  // there is the one that completes at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("unexpected result transaction: grey %0d inside %0b",
                   out_tdata, out_tuser);
        end
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        if (out_tdata !== oldest_pixel.grey || out_tuser !== oldest_pixel.in_ramp) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display({"mismatch at pixel (%0d,%0d): expected grey %0d inside %0b, ",
                      "got grey %0d inside %0b"},
                     oldest_pixel.col, oldest_pixel.row, oldest_pixel.grey,
                     oldest_pixel.in_ramp, out_tdata, out_tuser);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction happens on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_pixels.size());
    $display("radial_gradient_pixel_generator_test: FAIL");
    $finish;
  end

  // Test sequence. Reset is held from the start and released once.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_exact_radius();
    test_random_configs();
    test_backpressure();
    // Anything arriving now would be a stray result; give it time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && expected_pixels.size() == 0) begin
      $display("radial_gradient_pixel_generator_test: PASS");
    end else begin
      $display("radial_gradient_pixel_generator_test: FAIL");
    end
    $finish;
  end

endmodule
